// ===== hdl/hcf_pkg.sv =====
`timescale 1ns / 1ps

package hcf_pkg;

    localparam int unsigned WORD_W     = 35;
    localparam int unsigned COUNT_W    = 6;
    localparam int unsigned GROUPS     = 7;

    localparam logic [WORD_W-1:0]  PREAMBLE_BITS = 35'h0_19FF_FFFF;
    localparam logic [COUNT_W-1:0] PREAMBLE_LEN  = 6'd29;
    localparam logic [COUNT_W-1:0] WORD_LEN      = 6'd35;
    localparam logic [WORD_W-1:0]  TRAILER_BITS  = 35'h0_0000_7FFF;
    localparam logic [COUNT_W-1:0] TRAILER_LEN   = 6'd15;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    // One request as handed from the front to the back
    typedef struct packed {
        logic       pre;       // preamble goes out first
        logic       endf;      // end of frame: coded CRC then trailer
        logic [7:0] b_first;   // data byte, or CRC low byte on end
        logic [7:0] b_second;  // data byte, or CRC high byte on end
    } hcf_cmd_t;

endpackage

// ===== hdl/hamming_crc_frame_encoder.sv =====
`timescale 1ns / 1ps
// Requests pass through the queue into the output register. Throughput: one result per
// cycle while out_ready is high. A data request in a frame gives one word, a frame's first
// a preamble and a word, an end request the CRC word and trailer (preamble first if it
// opens a frame). A two-entry queue between the CRC front end and the output sequencer lets
// both stall. Reset clears the frame flag, loads the CRC with 0xFFFF and empties the queue.
module hamming_crc_frame_encoder
    import hcf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic [7:0]         byte_first,
    input  logic [7:0]         byte_second,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [WORD_W-1:0]  symbol_bits,
    output logic [COUNT_W-1:0] bit_count,
    output logic               last_in_run,
    output logic               frame_done
);

    logic     q_full;
    logic     q_push;
    logic     q_pop;
    logic     head_valid;
    hcf_cmd_t push_cmd;
    hcf_cmd_t head_cmd;

    hcf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .byte_first  (byte_first),
        .byte_second (byte_second),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    hcf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    hcf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .symbol_bits (symbol_bits),
        .bit_count   (bit_count),
        .last_in_run (last_in_run),
        .frame_done  (frame_done)
    );

endmodule

// ===== hdl/hcf_front.sv =====
`timescale 1ns / 1ps

module hcf_front
    import hcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       func,
    input  logic [7:0] byte_first,
    input  logic [7:0] byte_second,
    input  logic       q_full,
    output logic       q_push,
    output hcf_cmd_t   q_cmd
);

    logic        in_frame_reg;
    logic        in_frame_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] crc_upd;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;
    assign crc_upd  = crc_byte(crc_byte(crc_reg, byte_first), byte_second);

    // Classify the request for the back end
    always_comb
    begin
        q_cmd.pre  = !in_frame_reg;
        q_cmd.endf = (func == FUNC_END);
        if (func == FUNC_END)
        begin
            q_cmd.b_first  = crc_reg[7:0];
            q_cmd.b_second = crc_reg[15:8];
        end
        else
        begin
            q_cmd.b_first  = byte_first;
            q_cmd.b_second = byte_second;
        end
    end

    // Advance frame state and CRC on each accepted request
    always_comb
    begin
        in_frame_next = in_frame_reg;
        crc_next      = crc_reg;
        if (q_push)
        begin
            if (func == FUNC_END)
            begin
                in_frame_next = 1'b0;
                crc_next      = CRC_INIT;
            end
            else
            begin
                in_frame_next = 1'b1;
                crc_next      = crc_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            crc_reg      <= CRC_INIT;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            crc_reg      <= crc_next;
        end
    end

endmodule

// ===== hdl/hcf_queue.sv =====
`timescale 1ns / 1ps

module hcf_queue
    import hcf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  hcf_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output hcf_cmd_t head_cmd
);

    hcf_cmd_t    mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Store incoming request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== hdl/hcf_back.sv =====
`timescale 1ns / 1ps

module hcf_back
    import hcf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  hcf_cmd_t           head_cmd,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [WORD_W-1:0]  symbol_bits,
    output logic [COUNT_W-1:0] bit_count,
    output logic               last_in_run,
    output logic               frame_done
);

    typedef enum logic [2:0] {
        SEQ_HEAD  = 3'b001,
        SEQ_WORD  = 3'b010,
        SEQ_TRAIL = 3'b100
    } seq_t;

    typedef enum logic [2:0] {
        KIND_PRE   = 3'b001,
        KIND_WORD  = 3'b010,
        KIND_TRAIL = 3'b100
    } kind_t;

    seq_t               seq_reg;
    seq_t               seq_next;
    kind_t              kind;
    logic               load;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  symbol_bits_reg;
    logic [COUNT_W-1:0] bit_count_reg;
    logic               last_in_run_reg;
    logic               frame_done_reg;
    logic [WORD_W-1:0]  word_bits;
    logic [WORD_W-1:0]  sel_bits;
    logic [COUNT_W-1:0] sel_count;
    logic               sel_last;

    function automatic logic [6:0] code74(input logic [3:0] n);
        logic [6:0] c;
        unique case (n)
            4'h0: c = 7'h00;
            4'h1: c = 7'h70;
            4'h2: c = 7'h4C;
            4'h3: c = 7'h3C;
            4'h4: c = 7'h2A;
            4'h5: c = 7'h5A;
            4'h6: c = 7'h66;
            4'h7: c = 7'h16;
            4'h8: c = 7'h69;
            4'h9: c = 7'h19;
            4'hA: c = 7'h25;
            4'hB: c = 7'h55;
            4'hC: c = 7'h43;
            4'hD: c = 7'h33;
            4'hE: c = 7'h0F;
            default: c = 7'h7F;
        endcase
        return c;
    endfunction

    function automatic logic [WORD_W-1:0] code_pair(input logic [7:0] a, input logic [7:0] b);
        logic [6:0]        ah;
        logic [6:0]        al;
        logic [6:0]        bh;
        logic [6:0]        bl;
        logic [3:0]        g;
        logic [WORD_W-1:0] w;
        ah = code74(a[7:4]);
        al = code74(a[3:0]);
        bh = code74(b[7:4]);
        bl = code74(b[3:0]);
        w  = '0;
        for (int i = 0; i < GROUPS; i++) begin
            g = {bl[i], al[i], bh[i], ah[i]};
            w[i*5 +: 5] = {(g == 4'd0), g};
        end
        return w;
    endfunction

    assign word_bits = code_pair(head_cmd.b_first, head_cmd.b_second);
    assign load      = head_valid && (!out_valid_reg || out_ready);

    // Pick the kind of result due for the head request
    always_comb
    begin
        unique case (seq_reg)
            SEQ_HEAD:  kind = head_cmd.pre ? KIND_PRE : KIND_WORD;
            SEQ_WORD:  kind = KIND_WORD;
            SEQ_TRAIL: kind = KIND_TRAIL;
            default:   kind = KIND_WORD;
        endcase
    end

    always_comb
    begin
        seq_next  = seq_reg;
        pop       = 1'b0;
        sel_bits  = word_bits;
        sel_count = WORD_LEN;
        sel_last  = 1'b0;
        unique case (kind)
            KIND_PRE:
            begin
                sel_bits  = PREAMBLE_BITS;
                sel_count = PREAMBLE_LEN;
                if (load)
                begin
                    seq_next = SEQ_WORD;
                end
            end
            KIND_WORD:
            begin
                sel_last = !head_cmd.endf;
                if (load)
                begin
                    if (head_cmd.endf)
                    begin
                        seq_next = SEQ_TRAIL;
                    end
                    else
                    begin
                        seq_next = SEQ_HEAD;
                        pop      = 1'b1;
                    end
                end
            end
            KIND_TRAIL:
            begin
                sel_bits  = TRAILER_BITS;
                sel_count = TRAILER_LEN;
                sel_last  = 1'b1;
                if (load)
                begin
                    seq_next = SEQ_HEAD;
                    pop      = 1'b1;
                end
            end
            default:
            begin
                seq_next = SEQ_HEAD;
            end
        endcase
    end

    // Hold the result until taken; load the next one behind it
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            symbol_bits_reg <= sel_bits;
            bit_count_reg   <= sel_count;
            last_in_run_reg <= sel_last;
            frame_done_reg  <= (kind == KIND_TRAIL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= SEQ_HEAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg <= seq_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign symbol_bits = symbol_bits_reg;
    assign bit_count   = bit_count_reg;
    assign last_in_run = last_in_run_reg;
    assign frame_done  = frame_done_reg;

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_done_reg |-> last_in_run_reg && bit_count_reg == TRAILER_LEN)
        else $error("trailer result not closing the run");

    a_mid_run_head: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg != SEQ_HEAD |-> head_valid)
        else $error("request left the queue before its results were sent");

    a_trail_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == SEQ_TRAIL |-> head_cmd.endf)
        else $error("trailer due for a data request");

    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg && last_in_run_reg)
        else $error("request dropped without its last result");

endmodule
